// File: design/assert_macros.svh
// Concurrent assertion helpers, clocked on aclk and muted in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PTCF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

`define PTCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ptcf_pkg.sv
package ptcf_pkg;

    localparam int FrameLen   = 7;
    localparam int QueueDepth = 2;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);
    localparam int IdxW       = $clog2(FrameLen);

    localparam logic [1:0] FUNC_MOVE   = 2'd0;
    localparam logic [1:0] FUNC_PRESET = 2'd1;
    localparam logic [1:0] FUNC_MODE   = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    localparam logic [2:0] DIR_UP    = 3'd0;
    localparam logic [2:0] DIR_DOWN  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;

    localparam logic [7:0] CMD_UP    = 8'h08;
    localparam logic [7:0] CMD_DOWN  = 8'h10;
    localparam logic [7:0] CMD_LEFT  = 8'h04;
    localparam logic [7:0] CMD_RIGHT = 8'h02;

    localparam logic [1:0] ACT_STORE  = 2'd0;
    localparam logic [1:0] ACT_RECALL = 2'd1;
    localparam logic [1:0] ACT_ERASE  = 2'd2;

    localparam logic [7:0] CMD_STORE  = 8'h03;
    localparam logic [7:0] CMD_RECALL = 8'h07;
    localparam logic [7:0] CMD_ERASE  = 8'h05;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] AUTO_CMD1 = 8'h90;
    localparam logic [6:0] MAX_SPEED = 7'd100;
    // 63/100 as a 16-bit fraction, exact for floor() over speeds 0..100
    localparam logic [15:0] SPEED_RECIP = 16'd41288;

    typedef struct packed {
        logic [7:0] address;
        logic [7:0] cmd1;
        logic [7:0] cmd2;
        logic [7:0] data1;
        logic [7:0] data2;
    } frame_fields_t;

    typedef struct packed {
        logic             full;
        logic             empty;
        logic [QCntW-1:0] count;
    } queue_status_t;

    function automatic logic [7:0] dir_code(input logic [2:0] dir);
        logic [7:0] code;
        unique case (dir)
            DIR_UP:    code = CMD_UP;
            DIR_DOWN:  code = CMD_DOWN;
            DIR_LEFT:  code = CMD_LEFT;
            DIR_RIGHT: code = CMD_RIGHT;
            default:   code = 8'h00;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] preset_code(input logic [1:0] act);
        logic [7:0] code;
        unique case (act)
            ACT_STORE:  code = CMD_STORE;
            ACT_RECALL: code = CMD_RECALL;
            ACT_ERASE:  code = CMD_ERASE;
            default:    code = 8'h00;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] speed_scale(input logic [7:0] spd);
        logic [6:0]  s;
        logic [22:0] p;
        s = (spd > 8'(MAX_SPEED)) ? MAX_SPEED : spd[6:0];
        p = 23'(s) * 23'(SPEED_RECIP);
        return {2'b00, p[21:16]};
    endfunction

endpackage

// File: design/ptcf_front.sv
module ptcf_front
    import ptcf_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    func,
    input  logic [7:0]    address,
    input  logic [2:0]    direction,
    input  logic [7:0]    speed,
    input  logic [1:0]    preset_action,
    input  logic [7:0]    preset_number,
    input  logic          auto_mode,
    input  queue_status_t q_status,
    output logic          push_valid,
    output frame_fields_t push_fields
);

    logic          valid_reg, valid_next;
    frame_fields_t ent_reg, ent_next;
    frame_fields_t ent_new;
    logic          take;

    assign in_ready    = !valid_reg || !q_status.full;
    assign take        = in_valid && in_ready;
    assign push_valid  = valid_reg;
    assign push_fields = ent_reg;

    always_comb begin
        ent_new         = '0;
        ent_new.address = address;
        unique case (func)
            FUNC_MOVE: begin
                ent_new.cmd2  = dir_code(direction);
                ent_new.data1 = speed_scale(speed);
            end
            FUNC_PRESET: begin
                ent_new.cmd2  = preset_code(preset_action);
                ent_new.data2 = preset_number;
            end
            FUNC_MODE: begin
                ent_new.cmd1 = auto_mode ? AUTO_CMD1 : 8'h00;
            end
            default: begin
                ent_new = '0;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        ent_next   = ent_reg;
        if (take) begin
            valid_next = (func != FUNC_NONE);
            ent_next   = ent_new;
        end else if (valid_reg && !q_status.full) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        ent_reg <= ent_next;
    end

endmodule

// File: design/ptcf_queue.sv
module ptcf_queue
    import ptcf_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  frame_fields_t push_fields,
    input  logic          pop,
    output frame_fields_t head_fields,
    output queue_status_t status
);

    frame_fields_t    mem [QueueDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == QCntW'(QueueDepth));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_fields  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_fields;
        end
    end

endmodule

// File: design/ptcf_back.sv
module ptcf_back
    import ptcf_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  queue_status_t q_status,
    input  frame_fields_t head_fields,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    frame_byte,
    output logic          last_byte
);

    logic [FrameLen*8-1:0] frame_reg, frame_next;
    logic [IdxW-1:0]       idx_reg, idx_next;
    logic                  busy_reg, busy_next;
    logic [7:0]            checksum;
    logic                  advance;

    assign out_valid  = busy_reg;
    assign frame_byte = frame_reg[7:0];
    assign last_byte  = (idx_reg == IdxW'(FrameLen - 1));
    assign advance    = busy_reg && out_ready;
    assign pop        = !q_status.empty && (!busy_reg || (advance && last_byte));
    assign checksum   = head_fields.address + head_fields.cmd1 + head_fields.cmd2
                      + head_fields.data1 + head_fields.data2;

    always_comb begin
        frame_next = frame_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        if (pop) begin
            frame_next = {checksum, head_fields.data2, head_fields.data1,
                          head_fields.cmd2, head_fields.cmd1, head_fields.address,
                          SYNC_BYTE};
            idx_next   = '0;
            busy_next  = 1'b1;
        end else if (advance) begin
            frame_next = {8'h00, frame_reg[FrameLen*8-1:8]};
            idx_next   = idx_reg + 1'b1;
            busy_next  = !last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
        frame_reg <= frame_next;
    end

endmodule

// File: design/pan_tilt_command_framer.sv
// channel | dir | width | contents
// s_      | in  | 32    | one request: kind, address, move, preset and mode fields
// m_      | out | 8 + 1 | one frame byte, tlast on the checksum byte
//
// A request emits 7 bytes, one per cycle while m_tready is high; the byte
// serializer in the back end paces the requests.
// A request passes the front register, the queue and the serializer before its first byte.
// Reset (aresetn low, synchronous) empties the front register, queue and serializer.
// A stalled m_ side fills the two-entry queue, then the front register, then
// drops s_tready; requests of the unused kind are taken and dropped.
`include "assert_macros.svh"

module pan_tilt_command_framer
    import ptcf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] func, [9:2] address, [12:10] direction, [20:13] speed,
    // [22:21] preset_action, [30:23] preset_number, [31] auto_mode
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] frame_byte
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    queue_status_t q_status;
    frame_fields_t push_fields;
    frame_fields_t head_fields;
    logic          push_valid;
    logic          pop;

    ptcf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .func          (s_tdata[1:0]),
        .address       (s_tdata[9:2]),
        .direction     (s_tdata[12:10]),
        .speed         (s_tdata[20:13]),
        .preset_action (s_tdata[22:21]),
        .preset_number (s_tdata[30:23]),
        .auto_mode     (s_tdata[31]),
        .q_status      (q_status),
        .push_valid    (push_valid),
        .push_fields   (push_fields)
    );

    ptcf_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push_valid),
        .push_fields (push_fields),
        .pop         (pop),
        .head_fields (head_fields),
        .status      (q_status)
    );

    ptcf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_status    (q_status),
        .head_fields (head_fields),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .frame_byte  (m_tdata),
        .last_byte   (m_tlast)
    );

    `PTCF_ASSERT(a_queue_bound, q_status.count <= QCntW'(QueueDepth), "queue overfilled")
    `PTCF_ASSERT_NEXT(a_frame_contig, m_tvalid && m_tready && !m_tlast, m_tvalid,
        "frame broken before checksum byte")
    `PTCF_ASSERT_NEXT(a_frame_chain, m_tvalid && m_tready && m_tlast && !q_status.empty,
        m_tvalid && m_tdata == SYNC_BYTE, "queued frame not started after checksum byte")
    `PTCF_ASSERT(a_pop_legal, !(pop && q_status.empty), "pop from empty queue")

endmodule
